@@ src/gcdb_pkg.sv @@
package gcdb_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    // datapath widths
    localparam int D_W         = 34;  // angle in degrees * 2^24 before wrapping
    localparam int TRIG_W      = 32;  // Q30 sine / cosine and Q30 products
    localparam int ANG_W       = 36;  // CORDIC vector and angle accumulators
    localparam int XY_W        = 34;  // bearing atan2 operands
    localparam int A_W         = 31;  // haversine term, 0 .. 1.0 in Q30
    localparam int RAD_W       = 61;  // radicand of the square root
    localparam int SQRT_W      = 62;  // square root working width
    localparam int ROOT_W      = 31;
    localparam int SQRT_STAGES = 31;
    localparam int CQ_W        = 33;
    localparam int R100_W      = 30;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [ANG_W-1:0] PI_Q32 = ANG_W'(PI_Q60 >> 28);
    localparam logic signed [31:0] DEG_TO_RAD_K = 32'((PI_Q60 >> 24) / 180);
    localparam logic signed [31:0] RAD_TO_DEG_M = 32'((64'd180 << 55) / (PI_Q60 >> 28));
    localparam logic signed [D_W:0] TURN_Q24    = (D_W+1)'(64'd360 << 24);
    localparam logic signed [D_W:0] HALF_Q24    = (D_W+1)'(64'd180 << 24);
    localparam logic signed [D_W:0] QUARTER_Q24 = (D_W+1)'(64'd90 << 24);
    localparam logic signed [ANG_W-1:0] CORDIC_START = ANG_W'(652032874);
    localparam logic [A_W-1:0] ONE_Q30 = A_W'(64'd1 << 30);
    localparam logic signed [31:0] BEARING_MAX = 32'sd1509949440;
    localparam logic [22:0] RADIUS_RESET = 23'd6371000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_LAT     = 2'd0,
        CFG_GOAL_LNG     = 2'd1,
        CFG_EARTH_RADIUS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [30:0] cur_lat;
        logic signed [31:0] cur_lng;
    } t_pos;

    typedef struct packed {
        logic [31:0]        distance_cm;
        logic signed [31:0] bearing;
    } t_result;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s1;
        logic signed [TRIG_W-1:0] c1;
        logic signed [TRIG_W-1:0] s2;
        logic signed [TRIG_W-1:0] c2;
        logic signed [TRIG_W-1:0] shl;
        logic signed [TRIG_W-1:0] shn;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] cn;
    } t_trig;

    // right shift by n >= 1, rounding half away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int unsigned n);
        logic [63:0] m;
        logic [63:0] q;
        m = v[63] ? (64'd0 - v) : v;
        q = (m + (64'd1 << (n - 1))) >> n;
        return v[63] ? $signed(64'd0 - q) : $signed(q);
    endfunction

    // bitwise long division, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in radians * 2^32 from the arctangent series
    function automatic logic [ANG_W-1:0] atan_entry(input int i);
        logic signed [63:0] acc;
        logic signed [63:0] t;
        int e;
        if (i == 0) return ANG_W'(PI_Q60 >> 30);
        acc = '0;
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                t   = $signed(udiv64(64'd1 << (62 - e), 64'(2 * k + 1)));
                acc = k[0] ? acc - t : acc + t;
            end
        end
        return ANG_W'(rshr(acc, 30));
    endfunction

endpackage

@@ src/great_circle_distance_bearing.sv @@
// Structure: two CORDIC chains of one stage per step plus a 31-stage root.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Reset (synchronous, active low) empties the pipeline and sets the goal to 0,0
// and the radius to 6371000 m.
module great_circle_distance_bearing
    import gcdb_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_pos                  i_pos,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_result               o_result,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [30:0]      r_goal_lat;
    logic signed [31:0]      r_goal_lng;
    logic [22:0]             r_earth_radius;
    logic [R100_W-1:0]       r_r100;

    logic                    en;
    logic signed [D_W-1:0]   ang_lat1, ang_lat2, ang_hlat, ang_hlng, ang_lng;
    t_trig                   trig;
    logic                    sc_valid;
    logic                    mix_valid;
    logic [A_W-1:0]          mix_a;
    logic signed [XY_W-1:0]  mix_y, mix_x;
    logic [A_W-1:0]          a_rest;
    logic                    sq_valid;
    logic [ROOT_W-1:0]       root_a, root_b;
    logic signed [XY_W-1:0]  r_dly_y [0:SQRT_STAGES-1];
    logic signed [XY_W-1:0]  r_dly_x [0:SQRT_STAGES-1];
    logic                    at_valid;
    logic signed [ANG_W-1:0] z_dist, z_bear;

    logic                    r_fv1, r_fv2, r_out_valid;
    logic [CQ_W-1:0]         r_cq;
    logic signed [63:0]      cq_full;
    logic signed [63:0]      r_pb;
    logic [63:0]             r_pd;
    logic signed [63:0]      b_full;
    logic signed [31:0]      n_b, r_b;
    logic [63:0]             d_full;
    logic [31:0]             n_dist;
    t_result                 r_out;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_lat     <= '0;
            r_goal_lng     <= '0;
            r_earth_radius <= RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_GOAL_LAT:     r_goal_lat     <= i_cfg_data[30:0];
                CFG_GOAL_LNG:     r_goal_lng     <= i_cfg_data;
                CFG_EARTH_RADIUS: r_earth_radius <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r100 <= R100_W'(r_earth_radius) * R100_W'(100);
    end

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // angles in degrees * 2^24: doubled latitudes, half latitude delta, half and full longitude delta
    always_comb begin
        ang_lat1 = D_W'(i_pos.cur_lat) <<< 1;
        ang_lat2 = D_W'(r_goal_lat) <<< 1;
        ang_hlat = D_W'(r_goal_lat) - D_W'(i_pos.cur_lat);
        ang_hlng = D_W'(r_goal_lng) - D_W'(i_pos.cur_lng);
        ang_lng  = ang_hlng <<< 1;
    end

    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_ang(ang_lat1), .o_valid(sc_valid), .o_sin(trig.s1), .o_cos(trig.c1)
    );

    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_ang(ang_lat2), .o_valid(), .o_sin(trig.s2), .o_cos(trig.c2)
    );

    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_hlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_ang(ang_hlat), .o_valid(), .o_sin(trig.shl), .o_cos()
    );

    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_hlng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_ang(ang_hlng), .o_valid(), .o_sin(trig.shn), .o_cos()
    );

    gcdb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_ang(ang_lng), .o_valid(), .o_sin(trig.sn), .o_cos(trig.cn)
    );

    gcdb_mix u_mix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(sc_valid),
        .i_trig(trig), .o_valid(mix_valid), .o_a(mix_a), .o_y(mix_y), .o_x(mix_x)
    );

    assign a_rest = ONE_Q30 - mix_a;

    gcdb_sqrt u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(mix_valid),
        .i_v({mix_a, 30'd0}), .o_valid(sq_valid), .o_root(root_a)
    );

    gcdb_sqrt u_sqrt_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(mix_valid),
        .i_v({a_rest, 30'd0}), .o_valid(), .o_root(root_b)
    );

    // hold bearing operands alongside the square roots
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_y[0] <= mix_y;
            r_dly_x[0] <= mix_x;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                r_dly_y[k] <= r_dly_y[k-1];
                r_dly_x[k] <= r_dly_x[k-1];
            end
        end
    end

    gcdb_atan2 #(.STEPS(CORDIC_STEPS)) u_at_dist (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(sq_valid),
        .i_y($signed(ANG_W'(root_a))), .i_x($signed(ANG_W'(root_b))),
        .o_valid(at_valid), .o_z(z_dist)
    );

    gcdb_atan2 #(.STEPS(CORDIC_STEPS)) u_at_bear (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(sq_valid),
        .i_y(ANG_W'(r_dly_y[SQRT_STAGES-1])), .i_x(ANG_W'(r_dly_x[SQRT_STAGES-1])),
        .o_valid(), .o_z(z_bear)
    );

    // scale central angle to centimetres and radians to degrees
    always_comb begin
        cq_full = rshr(64'(z_dist), 1);
        b_full  = rshr(r_pb, 32);
        if (b_full > 64'(BEARING_MAX)) begin
            n_b = BEARING_MAX;
        end else if (b_full < -64'(BEARING_MAX)) begin
            n_b = -BEARING_MAX;
        end else begin
            n_b = 32'(b_full);
        end
        d_full = (r_pd + (64'd1 << 29)) >> 30;
        n_dist = (d_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(d_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv1       <= 1'b0;
            r_fv2       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_fv1       <= at_valid;
            r_fv2       <= r_fv1;
            r_out_valid <= r_fv2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cq              <= (cq_full < 0) ? '0 : CQ_W'(cq_full);
            r_pb              <= 64'(z_bear) * 64'(RAD_TO_DEG_M);
            r_pd              <= 64'(r_cq) * 64'(r_r100);
            r_b               <= n_b;
            r_out.distance_cm <= n_dist;
            r_out.bearing     <= r_b;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output register is empty");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.bearing <= BEARING_MAX) && (o_result.bearing >= -BEARING_MAX))
        else $error("bearing outside +-180 degrees");

    a_hav_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_valid |-> (mix_a <= ONE_Q30))
        else $error("haversine term above one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule

@@ src/gcdb_sincos.sv @@
module gcdb_sincos
    import gcdb_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [D_W-1:0]    i_ang,
    output logic                     o_valid,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    localparam int LAT = STEPS + 6;

    logic [LAT-1:0]           r_vld;
    logic signed [D_W-1:0]    r_d;
    logic signed [D_W-1:0]    r_w;
    logic signed [D_W-1:0]    n_w;
    logic signed [TRIG_W-1:0] r_m;
    logic signed [TRIG_W-1:0] n_m;
    logic                     n_neg;
    logic [STEPS+2:0]         r_neg;
    logic signed [63:0]       r_p;
    logic signed [ANG_W-1:0]  r_x [0:STEPS];
    logic signed [ANG_W-1:0]  r_y [0:STEPS];
    logic signed [ANG_W-1:0]  r_z [0:STEPS];
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [D_W:0]      d_ext;
    logic signed [D_W:0]      w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // wrap into -180 .. 180, then fold into -90 .. 90
    always_comb begin
        d_ext = (D_W+1)'(r_d);
        if (d_ext >= HALF_Q24) begin
            n_w = D_W'(d_ext - TURN_Q24);
        end else if (d_ext < -HALF_Q24) begin
            n_w = D_W'(d_ext + TURN_Q24);
        end else begin
            n_w = r_d;
        end
        w_ext = (D_W+1)'(r_w);
        if (w_ext > QUARTER_Q24) begin
            n_m   = TRIG_W'(w_ext - HALF_Q24);
            n_neg = 1'b1;
        end else if (w_ext < -QUARTER_Q24) begin
            n_m   = TRIG_W'(w_ext + HALF_Q24);
            n_neg = 1'b1;
        end else begin
            n_m   = TRIG_W'(w_ext);
            n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= i_ang;
            r_w    <= n_w;
            r_m    <= n_m;
            r_neg  <= {r_neg[STEPS+1:0], n_neg};
            r_p    <= 64'(r_m) * 64'(DEG_TO_RAD_K);
            r_x[0] <= CORDIC_START;
            r_y[0] <= '0;
            r_z[0] <= ANG_W'(rshr(r_p, 28));
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_rot
        localparam logic signed [ANG_W-1:0] ATN = $signed(atan_entry(k));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ATN;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ATN;
                end
            end
        end
    end

    // undo the fold by negating both
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= TRIG_W'(r_neg[STEPS+2] ? -r_y[STEPS] : r_y[STEPS]);
            r_cos <= TRIG_W'(r_neg[STEPS+2] ? -r_x[STEPS] : r_x[STEPS]);
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

@@ src/gcdb_mix.sv @@
module gcdb_mix
    import gcdb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_trig                  i_trig,
    output logic                   o_valid,
    output logic [A_W-1:0]         o_a,
    output logic signed [XY_W-1:0] o_y,
    output logic signed [XY_W-1:0] o_x
);

    localparam int LAT = 4;

    logic [LAT-1:0]           r_vld;
    logic signed [63:0]       r_p_hh, r_p_cc, r_p_nn, r_p_sc, r_p_cs, r_p_s1c2;
    logic signed [TRIG_W-1:0] r_cn1, r_cn2;
    logic signed [TRIG_W-1:0] r_q_hh, r_q_cc, r_q_nn, r_q_sc, r_q_cs, r_q_s1c2;
    logic signed [63:0]       r_p_ccnn, r_p_scn;
    logic signed [TRIG_W-1:0] r_q_hh3, r_q_sc3, r_q_cs3;
    logic signed [XY_W-1:0]   a_sum;
    logic [A_W-1:0]           n_a;
    logic [A_W-1:0]           r_a;
    logic signed [XY_W-1:0]   r_y, r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_comb begin
        a_sum = XY_W'(r_q_hh3) + XY_W'(rshr(r_p_ccnn, 30));
        if (a_sum < 0) begin
            n_a = '0;
        end else if (a_sum > $signed(XY_W'(ONE_Q30))) begin
            n_a = ONE_Q30;
        end else begin
            n_a = A_W'(a_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_hh   <= 64'(i_trig.shl) * 64'(i_trig.shl);
            r_p_cc   <= 64'(i_trig.c1) * 64'(i_trig.c2);
            r_p_nn   <= 64'(i_trig.shn) * 64'(i_trig.shn);
            r_p_sc   <= 64'(i_trig.sn) * 64'(i_trig.c2);
            r_p_cs   <= 64'(i_trig.c1) * 64'(i_trig.s2);
            r_p_s1c2 <= 64'(i_trig.s1) * 64'(i_trig.c2);
            r_cn1    <= i_trig.cn;

            r_q_hh   <= TRIG_W'(rshr(r_p_hh, 30));
            r_q_cc   <= TRIG_W'(rshr(r_p_cc, 30));
            r_q_nn   <= TRIG_W'(rshr(r_p_nn, 30));
            r_q_sc   <= TRIG_W'(rshr(r_p_sc, 30));
            r_q_cs   <= TRIG_W'(rshr(r_p_cs, 30));
            r_q_s1c2 <= TRIG_W'(rshr(r_p_s1c2, 30));
            r_cn2    <= r_cn1;

            r_p_ccnn <= 64'(r_q_cc) * 64'(r_q_nn);
            r_p_scn  <= 64'(r_q_s1c2) * 64'(r_cn2);
            r_q_hh3  <= r_q_hh;
            r_q_sc3  <= r_q_sc;
            r_q_cs3  <= r_q_cs;

            r_a <= n_a;
            r_y <= XY_W'(r_q_sc3);
            r_x <= XY_W'(r_q_cs3) - XY_W'(rshr(r_p_scn, 30));
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_a     = r_a;
    assign o_y     = r_y;
    assign o_x     = r_x;

endmodule

@@ src/gcdb_sqrt.sv @@
module gcdb_sqrt
    import gcdb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_v,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQRT_STAGES-1:0] r_vld;
    logic [SQRT_W-1:0]      r_v   [0:SQRT_STAGES-1];
    logic [SQRT_W-1:0]      r_res [0:SQRT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_STAGES-2:0], i_valid};
        end
    end

    // one result bit per stage, restoring
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_bit
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (60 - 2 * k);
        logic [SQRT_W-1:0] v_in;
        logic [SQRT_W-1:0] res_in;
        logic [SQRT_W-1:0] trial;
        if (k == 0) begin : g_first
            assign v_in   = SQRT_W'(i_v);
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign res_in = r_res[k-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_in >= trial) begin
                    r_v[k]   <= v_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_v[k]   <= v_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[SQRT_STAGES-1];
    assign o_root  = ROOT_W'(r_res[SQRT_STAGES-1]);

endmodule

@@ src/gcdb_atan2.sv @@
module gcdb_atan2
    import gcdb_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [ANG_W-1:0] i_y,
    input  logic signed [ANG_W-1:0] i_x,
    output logic                    o_valid,
    output logic signed [ANG_W-1:0] o_z
);

    localparam int LAT = STEPS + 2;

    logic [LAT-1:0]          r_vld;
    logic [STEPS:0]          r_zero;
    logic signed [ANG_W-1:0] r_x [0:STEPS];
    logic signed [ANG_W-1:0] r_y [0:STEPS];
    logic signed [ANG_W-1:0] r_z [0:STEPS];
    logic signed [ANG_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // pre-rotate by pi when x is negative
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= {r_zero[STEPS-1:0], (i_x == '0) && (i_y == '0)};
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? PI_Q32 : -PI_Q32;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_vec
        localparam logic signed [ANG_W-1:0] ATN = $signed(atan_entry(k));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] < 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ATN;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ATN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[STEPS]) begin
                r_out <= '0;
            end else if (r_z[STEPS] > PI_Q32) begin
                r_out <= PI_Q32;
            end else if (r_z[STEPS] < -PI_Q32) begin
                r_out <= -PI_Q32;
            end else begin
                r_out <= r_z[STEPS];
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_z     = r_out;

endmodule

@@ verif/tb_great_circle_distance_bearing.sv @@
`timescale 1ns / 1ps

module tb_great_circle_distance_bearing;
    import gcdb_pkg::*;

    localparam int  N_STEPS     = 24;
    localparam int  N_ATAN      = 48;
    localparam int  HOLD_CYCLES = 500;
    localparam int  DRAIN_WAIT  = 120;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam longint LAT_MAX  = 754974720;
    localparam longint LNG_MAX  = 1509949440;
    localparam longint PI60     = longint'(64'h3243F6A8885A308D);
    localparam longint PI32     = PI60 >>> 28;
    localparam longint ONE30    = longint'(1) << 30;
    localparam longint START    = 652032874;
    localparam longint K_D2R    = (PI60 >>> 24) / 180;
    localparam longint M_R2D    = (longint'(180) << 55) / (PI60 >>> 28);
    localparam longint TURN24   = longint'(360) << 24;
    localparam longint HALF24   = longint'(180) << 24;
    localparam longint QUART24  = longint'(90) << 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_pos                  i_pos = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_result               o_result;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    great_circle_distance_bearing DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pos      (i_pos),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    longint  atan_tab [N_ATAN];
    longint  goal_lat = 0;
    longint  goal_lng = 0;
    longint  radius_m = 6371000;
    t_pos    pos_q [$];
    t_result route_q [$];
    int      send_idle = 0;
    int      recv_idle = 0;
    int      n_errors = 0;
    int      hold_left = 0;
    bit      held = 1'b0;

    function automatic longint round_shr(input longint v, input int n);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (n - 1))) >>> n;
        return (v < 0) ? -m : m;
    endfunction

    function automatic void sin_cos(input longint d, output longint s, output longint c);
        longint m, x, y, z, dx, dy;
        bit     flip;
        m = d % TURN24;
        x = START;
        y = 0;
        flip = 1'b0;
        if (m >= HALF24) m -= TURN24;
        if (m < -HALF24) m += TURN24;
        if (m > QUART24) begin
            m -= HALF24;
            flip = 1'b1;
        end else if (m < -QUART24) begin
            m += HALF24;
            flip = 1'b1;
        end
        z = round_shr(m * K_D2R, 28);
        for (int i = 0; i < N_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint arctan2(input longint y0, input longint x0);
        longint x, y, z, dx, dy;
        x = x0;
        y = y0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI32 : -PI32;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < N_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        if (z > PI32) z = PI32;
        if (z < -PI32) z = -PI32;
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v0);
        longint unsigned v, res, bt;
        v = v0;
        res = 0;
        bt = 64'd1 << 60;
        for (int i = 0; i < 31; i++) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return round_shr(a * b, 30);
    endfunction

    function automatic t_result route_to_goal(input t_pos p);
        longint lat1, lng1, s1, c1, s2, c2, shl, chl, shn, chn, sn, cn;
        longint a, z, cq, y, x, b;
        longint unsigned sa, sb, dist_cm;
        t_result r;
        lat1 = p.cur_lat;
        lng1 = p.cur_lng;
        sin_cos(2 * lat1, s1, c1);
        sin_cos(2 * goal_lat, s2, c2);
        sin_cos(goal_lat - lat1, shl, chl);
        sin_cos(goal_lng - lng1, shn, chn);
        sin_cos(2 * (goal_lng - lng1), sn, cn);
        a = qmul(shl, shl) + qmul(qmul(c1, c2), qmul(shn, shn));
        if (a < 0) a = 0;
        if (a > ONE30) a = ONE30;
        sa = floor_sqrt(longint'(a) << 30);
        sb = floor_sqrt(longint'(ONE30 - a) << 30);
        z = arctan2(longint'(sa), longint'(sb));
        cq = round_shr(z, 1);
        if (cq < 0) cq = 0;
        dist_cm = (longint'(cq) * (radius_m * 100) + (longint'(1) << 29)) >> 30;
        if (dist_cm > 64'hFFFF_FFFF) dist_cm = 64'hFFFF_FFFF;
        y = qmul(sn, c2);
        x = qmul(c1, s2) - qmul(qmul(s1, c2), cn);
        b = round_shr(arctan2(y, x) * M_R2D, 32);
        if (b > LNG_MAX) b = LNG_MAX;
        if (b < -LNG_MAX) b = -LNG_MAX;
        r.distance_cm = dist_cm[31:0];
        r.bearing = b[31:0];
        return r;
    endfunction

    initial begin
        longint acc, t;
        int e;
        atan_tab[0] = PI60 >>> 30;
        for (int i = 1; i < N_ATAN; i++) begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                e = i * (2 * k + 1);
                t = (longint'(1) << (62 - e)) / longint'(2 * k + 1);
                acc = k[0] ? acc - t : acc + t;
            end
            atan_tab[i] = round_shr(acc, 30);
        end
    end

    // driver: record each accepted item, then offer the next or hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) route_q.push_back(route_to_goal(i_pos));
            if (!i_valid || !o_stall) begin
                if (pos_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_valid <= 1'b1;
                    i_pos   <= pos_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (route_q.size() == 0) begin
                    $error("result with no item outstanding: %h", o_result);
                    n_errors++;
                end else begin
                    want = route_q.pop_front();
                    if (o_result.distance_cm !== want.distance_cm) begin
                        $error("distance_cm expected %0d actual %0d",
                               want.distance_cm, o_result.distance_cm);
                        n_errors++;
                    end
                    if (o_result.bearing !== want.bearing) begin
                        $error("bearing expected %0d actual %0d",
                               $signed(want.bearing), $signed(o_result.bearing));
                        n_errors++;
                    end
                end
            end
            // hold off once for a long stretch so the pipeline backs up
            if (!held && pos_q.size() >= 150) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_GOAL_LAT:     goal_lat = longint'($signed(data[30:0]));
            CFG_GOAL_LNG:     goal_lng = longint'($signed(data));
            CFG_EARTH_RADIUS: radius_m = longint'(data[22:0]);
            default: ;
        endcase
    endtask

    task automatic add_pos(input longint lat, input longint lng);
        t_pos p;
        p.cur_lat = lat[30:0];
        p.cur_lng = lng[31:0];
        pos_q.push_back(p);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pos_q.size() != 0 || i_valid || route_q.size() != 0);
    endtask

    function automatic longint rand_span(input longint lim);
        return longint'({$urandom, $urandom} % (2 * lim + 1)) - lim;
    endfunction

    task automatic add_random(input int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            if (kind < 2)
                add_pos(longint'($urandom), longint'($urandom));
            else if (kind < 4)
                add_pos(goal_lat + rand_span(longint'($urandom_range(1, 1 << 20))),
                        goal_lng + rand_span(longint'($urandom_range(1, 1 << 20))));
            else if (kind == 4)
                add_pos(-goal_lat + rand_span(4096), goal_lng + HALF24 / 2 + rand_span(4096));
            else
                add_pos(rand_span(LAT_MAX), rand_span(LNG_MAX));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults after reset, field extremes, poles, coincident point
        send_idle = 7;
        recv_idle = 65;
        add_pos(0, 0);
        add_pos(LAT_MAX, LNG_MAX);
        add_pos(-LAT_MAX, -LNG_MAX);
        add_pos(LAT_MAX, -LNG_MAX);
        add_pos(-LAT_MAX, LNG_MAX);
        add_pos(LAT_MAX, 0);
        add_pos(-LAT_MAX, 0);
        add_pos(0, LNG_MAX);
        add_pos(0, -LNG_MAX);
        add_pos(0, LNG_MAX / 2);
        add_pos(1, 1);
        add_pos(-1, -1);
        add_pos(longint'(31'sh3FFF_FFFF), longint'(32'sh7FFF_FFFF));
        add_pos(-(longint'(1) << 30), -(longint'(1) << 31));
        add_pos(-1, longint'(32'sh8000_0001));
        wait_idle();
        cfg_write(CFG_GOAL_LAT, 32'(LAT_MAX / 3));
        cfg_write(CFG_GOAL_LNG, 32'(LNG_MAX / 4));
        add_pos(LAT_MAX / 3, LNG_MAX / 4);
        add_pos(-LAT_MAX / 3, LNG_MAX / 4 + LNG_MAX);
        add_pos(LAT_MAX / 3 + 1, LNG_MAX / 4);
        add_pos(LAT_MAX / 3, LNG_MAX / 4 - LNG_MAX);
        wait_idle();

        for (int ph = 1; ph <= 6; ph++) begin
            case ((ph - 1) / 2)
                0: begin send_idle = 7;  recv_idle = 65; end
                1: begin send_idle = 65; recv_idle = 7;  end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            case (ph)
                1: begin
                    cfg_write(CFG_GOAL_LAT, 32'(LAT_MAX));
                    cfg_write(CFG_GOAL_LNG, 32'(LNG_MAX));
                    cfg_write(CFG_EARTH_RADIUS, 32'd8388607);
                end
                2: begin
                    cfg_write(CFG_GOAL_LAT, 32'(-LAT_MAX));
                    cfg_write(CFG_GOAL_LNG, 32'(-LNG_MAX));
                    cfg_write(CFG_EARTH_RADIUS, 32'd1);
                end
                3: begin
                    cfg_write(CFG_GOAL_LAT, 32'(rand_span(LAT_MAX)));
                    cfg_write(CFG_GOAL_LNG, 32'(rand_span(LNG_MAX)));
                    cfg_write(CFG_EARTH_RADIUS, 32'd0);
                end
                4: begin
                    cfg_write(CFG_GOAL_LAT, $urandom);
                    cfg_write(CFG_GOAL_LNG, $urandom);
                    cfg_write(CFG_EARTH_RADIUS, $urandom);
                end
                5: begin
                    cfg_write(CFG_SPARE, $urandom);
                    cfg_write(CFG_GOAL_LAT, 32'd0);
                    cfg_write(CFG_GOAL_LNG, 32'd0);
                    cfg_write(CFG_EARTH_RADIUS, 32'd6371000);
                end
                default: begin
                    cfg_write(CFG_GOAL_LAT, 32'(rand_span(LAT_MAX)));
                    cfg_write(CFG_GOAL_LNG, 32'(rand_span(LNG_MAX)));
                    cfg_write(CFG_EARTH_RADIUS, $urandom_range(1, 8388607));
                end
            endcase
            add_random(155);
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (route_q.size() != 0) begin
            $error("%0d results never arrived", route_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("PASS great_circle_distance_bearing");
        end else begin
            $display("FAIL great_circle_distance_bearing");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL great_circle_distance_bearing");
        $finish;
    end

endmodule
